// ----- sv/ssq_pkg.sv -----
`timescale 1ns / 1ps

package ssq_pkg;

	localparam logic OP_SLEEP = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_WOKEN = 2'd2;

	// Upper bound on the wakeups that a single tick may produce.
	localparam int MAX_WAKE = 16;
	localparam int WCNT_W = $clog2(MAX_WAKE + 1);

	typedef struct packed {
		logic        op;
		logic [7:0]  thread_id;
		logic [31:0] sleep_ticks;
		logic [5:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  woken_id;
		logic [63:0] wake_time;
		logic        last;
	} res_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} cell_cmd_t;

endpackage

// ----- sv/ssq_cell.sv -----
`timescale 1ns / 1ps

module ssq_cell #(
	parameter int TID_W = 8
) (
	input  logic                  clk,
	input  ssq_pkg::cell_cmd_t    cmd,
	input  logic                  valid,
	input  logic [63:0]           new_wake,
	input  logic [5:0]            new_prio,
	input  logic [TID_W-1:0]      new_tid,
	input  logic                  left_before,
	input  logic [63:0]           left_wake,
	input  logic [5:0]            left_prio,
	input  logic [TID_W-1:0]      left_tid,
	input  logic [63:0]           right_wake,
	input  logic [5:0]            right_prio,
	input  logic [TID_W-1:0]      right_tid,
	output logic [63:0]           wake,
	output logic [5:0]            prio,
	output logic [TID_W-1:0]      tid,
	output logic                  precedes
);
	import ssq_pkg::*;

	logic [63:0]      wake_q;
	logic [5:0]       prio_q;
	logic [TID_W-1:0] tid_q;

	// An empty cell always lets the new entry in; the sorted order makes the
	// set of cells that the new entry precedes a contiguous tail of the row.
	always_comb begin
		if (!valid) begin
			precedes = 1'b1;
		end else if (wake_q == new_wake) begin
			precedes = new_prio > prio_q;
		end else begin
			precedes = new_wake < wake_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && precedes) begin
			if (left_before) begin
				wake_q <= left_wake;
				prio_q <= left_prio;
				tid_q <= left_tid;
			end else begin
				wake_q <= new_wake;
				prio_q <= new_prio;
				tid_q <= new_tid;
			end
		end else if (cmd.shl) begin
			wake_q <= right_wake;
			prio_q <= right_prio;
			tid_q <= right_tid;
		end
	end

	assign wake = wake_q;
	assign prio = prio_q;
	assign tid = tid_q;

endmodule

// ----- sv/sorted_sleep_wakeup_queue_core.sv -----
`timescale 1ns / 1ps

// Channel   Ports                    Handshake
// request   req (req_t)              taken when start is high and busy is low
// result    result (res_t)           one cycle wide, marked by result_valid
//
// A sleep transaction first forms the wake time, then the row of cells makes room
// and stores it in one step, unless the queue is full. A tick transaction wakes
// at most MAX_WAKE threads and possibly none, with one result per thread woken,
// since the head cell is compared and the row shifts left once per wakeup.
// Reset clears the tick counter and the fill count; the cells hold no reset.
// The receiver cannot stall, so results go out as soon as they are formed.
module sorted_sleep_wakeup_queue_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int THREAD_ID_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ssq_pkg::req_t req,
	output logic          result_valid,
	output ssq_pkg::res_t result
);
	import ssq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS = 2'd1;
	localparam logic [1:0] ST_WAKE = 2'd2;

	logic [1:0]                state_q;
	logic [63:0]               tick_q;
	logic [CNT_W-1:0]          count_q;
	logic [WCNT_W-1:0]         wake_cnt_q;
	logic [63:0]               wt_q;
	logic [5:0]                prio_q;
	logic [THREAD_ID_BITS-1:0] tid_q;
	logic                      result_valid_q;
	res_t                      result_q;

	logic [15:0]               tid_ext;
	logic [THREAD_ID_BITS-1:0] tid_in;
	logic [15:0]               tid_out_ext;
	logic [15:0]               head_tid_ext;
	logic [64:0]               wt_sum;
	logic                      full;
	logic                      due0;
	logic                      due1;
	logic                      more;
	cell_cmd_t                 cmd;

	logic [63:0]               c_wake [QUEUE_DEPTH];
	logic [5:0]                c_prio [QUEUE_DEPTH];
	logic [THREAD_ID_BITS-1:0] c_tid [QUEUE_DEPTH];
	logic                      c_before [QUEUE_DEPTH];

	assign tid_ext = {8'd0, req.thread_id};
	assign tid_in = tid_ext[THREAD_ID_BITS-1:0];
	assign tid_out_ext = 16'(tid_q);
	assign head_tid_ext = 16'(c_tid[0]);
	assign wt_sum = {1'b0, tick_q} + {33'd0, req.sleep_ticks};

	assign full = count_q == CNT_W'(QUEUE_DEPTH);
	assign due0 = (count_q != '0) && (c_wake[0] <= tick_q)
		&& (wake_cnt_q < WCNT_W'(MAX_WAKE));
	assign due1 = (count_q > CNT_W'(1)) && (c_wake[1] <= tick_q);
	assign more = due1 && (wake_cnt_q < WCNT_W'(MAX_WAKE - 1));

	assign cmd.ins = (state_q == ST_INS) && !full;
	assign cmd.shl = (state_q == ST_WAKE) && due0;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic                      left_before;
			logic [63:0]               left_wake;
			logic [5:0]                left_prio;
			logic [THREAD_ID_BITS-1:0] left_tid;
			logic [63:0]               right_wake;
			logic [5:0]                right_prio;
			logic [THREAD_ID_BITS-1:0] right_tid;

			if (gi == 0) begin : g_first
				assign left_before = 1'b0;
				assign left_wake = wt_q;
				assign left_prio = prio_q;
				assign left_tid = tid_q;
			end else begin : g_mid
				assign left_before = c_before[gi-1];
				assign left_wake = c_wake[gi-1];
				assign left_prio = c_prio[gi-1];
				assign left_tid = c_tid[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign right_wake = c_wake[gi];
				assign right_prio = c_prio[gi];
				assign right_tid = c_tid[gi];
			end else begin : g_inner
				assign right_wake = c_wake[gi+1];
				assign right_prio = c_prio[gi+1];
				assign right_tid = c_tid[gi+1];
			end

			ssq_cell #(
				.TID_W(THREAD_ID_BITS)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.valid      (count_q > CNT_W'(gi)),
				.new_wake   (wt_q),
				.new_prio   (prio_q),
				.new_tid    (tid_q),
				.left_before(left_before),
				.left_wake  (left_wake),
				.left_prio  (left_prio),
				.left_tid   (left_tid),
				.right_wake (right_wake),
				.right_prio (right_prio),
				.right_tid  (right_tid),
				.wake       (c_wake[gi]),
				.prio       (c_prio[gi]),
				.tid        (c_tid[gi]),
				.precedes   (c_before[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q <= '0;
			count_q <= '0;
			wake_cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.op == OP_TICK) begin
							tick_q <= tick_q + 64'd1;
							wake_cnt_q <= '0;
							state_q <= ST_WAKE;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					result_valid_q <= 1'b1;
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_WAKE: begin
					if (due0) begin
						result_valid_q <= 1'b1;
						count_q <= count_q - CNT_W'(1);
						wake_cnt_q <= wake_cnt_q + WCNT_W'(1);
					end
					if (!(due0 && more)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, captured with the transaction.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			wt_q <= wt_sum[64] ? '1 : wt_sum[63:0];
			prio_q <= req.priority_req;
			tid_q <= tid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INS) begin
			result_q.kind <= full ? KIND_FULL : KIND_ACCEPT;
			result_q.woken_id <= tid_out_ext[7:0];
			result_q.wake_time <= wt_q;
			result_q.last <= 1'b1;
		end else if (state_q == ST_WAKE) begin
			result_q.kind <= KIND_WOKEN;
			result_q.woken_id <= head_tid_ext[7:0];
			result_q.wake_time <= c_wake[0];
			result_q.last <= !more;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_accept_grows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ACCEPT |-> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted sleep did not add an entry");

	a_woken_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_WOKEN |-> count_q == $past(count_q) - CNT_W'(1))
		else $error("woken thread did not leave the queue");

	a_woken_due: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_WOKEN |-> result.wake_time <= tick_q)
		else $error("thread woken before its wake time");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction taken without going busy");
`endif

endmodule
